// ===== hw/rtl/layer_dependency_scheduler_macros.svh =====
// ---------------------------------------------------------------------------
// Layer dependency scheduler assertion macros
// Concurrent checks clocked on clk, disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef LAYER_DEPENDENCY_SCHEDULER_MACROS_SVH
`define LAYER_DEPENDENCY_SCHEDULER_MACROS_SVH
`ifndef SYNTHESIS
`define LDS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("scheduler check failed");
`define LDS_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("scheduler forbidden condition");
`else
`define LDS_ASSERT(lbl, prop)
`define LDS_NEVER(lbl, cond)
`endif
`endif

// ===== hw/rtl/lds_pkg.sv =====
// ---------------------------------------------------------------------------
// lds_pkg
// Shared sizes, codes and entry layout of the layer dependency scheduler.
// ---------------------------------------------------------------------------
package lds_pkg;
	localparam int MAX_ENTRIES = 256;
	localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W = (CNT_W > 9) ? CNT_W : 9;
	localparam int BYTES_W = 40;

	localparam logic [2:0] REQ_ADD   = 3'd0;
	localparam logic [2:0] REQ_START = 3'd1;
	localparam logic [2:0] REQ_EXEC  = 3'd2;
	localparam logic [2:0] REQ_RKEEP = 3'd3;
	localparam logic [2:0] REQ_MARK  = 3'd4;

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_SEQ  = 2'd1;
	localparam logic [1:0] KIND_RES  = 2'd2;
	localparam logic [1:0] KIND_ATT  = 2'd3;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_REJECT = 2'd1,
		ST_NONE   = 2'd2
	} status_t;

	typedef struct packed {
		logic [31:0] size;
		logic [8:0]  dep;
		logic [1:0]  kind;
		logic [15:0] id;
	} entry_t;
endpackage

// ===== hw/rtl/lds_entry_ram.sv =====
// ---------------------------------------------------------------------------
// lds_entry_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
module lds_entry_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== hw/rtl/layer_dependency_scheduler.sv =====
// ---------------------------------------------------------------------------
// layer_dependency_scheduler
// Layer table with dependency tracking and output buffer accounting.
// ---------------------------------------------------------------------------
// Mark releases its target before the result. Execute allocates the first
// ready entry and, with release_outputs set, scans twice more to free unneeded
// outputs; each table scan reads one entry per cycle from the entry RAM.
// One request in flight at a time; the next is taken once the result sits
// in the output register. Reset clears flags, counters, entry count and
// release_outputs at once; entry contents are undefined until added.
`include "layer_dependency_scheduler_macros.svh"
module layer_dependency_scheduler import lds_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	// layer_id[15:0], dep_kind[17:16], dep_entry[26:18], out_bytes[58:27],
	// target_entry[66:59], zero fill
	input  logic [71:0]   s_tdata,
	// req_type[2:0]
	input  logic [2:0]    s_tuser,
	output logic          m_tvalid,
	input  logic          m_tready,
	// ran_entry[7:0], ran_layer_id[23:8], bytes_in_use[63:24], bytes_peak[103:64]
	output logic [103:0]  m_tdata,
	// status[1:0]
	output logic [1:0]    m_tuser,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);
	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_MARK, S_FIND, S_ALLOC, S_NEED, S_FREE, S_RESULT
	} state_t;

	state_t               state_q;
	logic                 rel_q;
	// latched request
	logic [2:0]           req_q;
	logic [15:0]          lid_q;
	logic [1:0]           kind_q;
	logic [8:0]           dep_q;
	logic [31:0]          bytes_q;
	logic [7:0]           tgt_q;
	// table state
	logic [CNT_W-1:0]     cnt_q;
	logic [MAX_ENTRIES-1:0] done_q, live_q, alloc_q, need_q;
	logic [BYTES_W-1:0]   now_q, max_q;
	// scan pipeline
	logic [CNT_W-1:0]     idx_q;
	logic                 vld_s1;
	logic [ADDR_W-1:0]    e_s1;
	// executed entry and result
	logic [ADDR_W-1:0]    run_q;
	logic [15:0]          run_id_q;
	logic [31:0]          run_size_q;
	status_t              st_q;

	entry_t               rd;
	logic [59-1:0]        rd_raw;
	logic [ADDR_W-1:0]    raddr;
	logic                 ram_we;
	entry_t               wentry;

	// APB: single register at byte address 0
	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;
	assign prdata = (paddr == 3'd0) ? {31'd0, rel_q} : 32'd0;

	assign s_tready = (state_q == S_IDLE);

	// ---- entry RAM ----
	assign wentry = '{size: bytes_q, dep: dep_q, kind: kind_q, id: lid_q};
	assign raddr  = (state_q == S_DECODE) ? ADDR_W'(tgt_q) : idx_q[ADDR_W-1:0];

	logic add_ok;
	logic dep_neg;
	logic [CMP_W-1:0] cnt_w;
	assign dep_neg = dep_q[8];
	assign cnt_w   = CMP_W'(cnt_q);
	// add accepted: room left, and residual/attention deps point at an existing entry
	assign add_ok = (cnt_q < CNT_W'(MAX_ENTRIES)) &&
		!(kind_q[1] && (dep_neg || CMP_W'(dep_q[7:0]) >= cnt_w));
	assign ram_we = (state_q == S_DECODE) && (req_q == REQ_ADD) && add_ok;

	lds_entry_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_ENTRIES)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q[ADDR_W-1:0]),
		.wdata (wentry),
		.raddr (raddr),
		.rdata (rd_raw)
	);
	assign rd = entry_t'(rd_raw);

	// ---- per-entry evaluation of the word read last cycle ----
	logic [ADDR_W-1:0] prev_idx, dep_idx;
	logic              rd_dep_neg, ready_s1, dep_in_tbl;
	assign prev_idx   = e_s1 - ADDR_W'(1);
	assign dep_idx    = ADDR_W'(rd.dep[7:0]);
	assign rd_dep_neg = rd.dep[8];
	assign dep_in_tbl = CMP_W'(rd.dep[7:0]) < cnt_w;
	always_comb begin
		ready_s1 = 1'b0;
		if (!done_q[e_s1]) begin
			unique case (rd.kind)
				KIND_NONE: ready_s1 = 1'b1;
				KIND_SEQ:  ready_s1 = (e_s1 == '0) || done_q[prev_idx];
				default:   ready_s1 = rd_dep_neg || (dep_in_tbl && done_q[dep_idx]);
			endcase
		end
	end

	logic scan_end, issue;
	assign issue    = idx_q < cnt_q;
	assign scan_end = !vld_s1 && !issue;

	// allocation arithmetic, saturating at 40 bits
	logic [BYTES_W:0]   sum;
	logic [BYTES_W-1:0] now_add;
	assign sum     = {1'b0, now_q} + (BYTES_W + 1)'(run_size_q);
	assign now_add = sum[BYTES_W] ? '1 : sum[BYTES_W-1:0];

	// release arithmetic, clamps at zero
	logic [BYTES_W-1:0] rel_size, now_sub;
	assign rel_size = (state_q == S_MARK) ? BYTES_W'(rd.size) : BYTES_W'(rd.size);
	assign now_sub  = (now_q >= rel_size) ? now_q - rel_size : '0;

	logic [ADDR_W-1:0] tgt_idx;
	assign tgt_idx = ADDR_W'(tgt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			rel_q    <= 1'b0;
			cnt_q    <= '0;
			done_q   <= '0;
			live_q   <= '0;
			alloc_q  <= '0;
			need_q   <= '0;
			now_q    <= '0;
			max_q    <= '0;
			idx_q    <= '0;
			vld_s1   <= 1'b0;
			m_tvalid <= 1'b0;
			st_q     <= ST_OK;
		end else begin
			if (cfg_wr && paddr == 3'd0) begin
				rel_q <= pwdata[0];
			end
			if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						req_q   <= s_tuser;
						lid_q   <= s_tdata[15:0];
						kind_q  <= s_tdata[17:16];
						dep_q   <= s_tdata[26:18];
						bytes_q <= s_tdata[58:27];
						tgt_q   <= s_tdata[66:59];
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					st_q     <= ST_OK;
					run_q    <= '0;
					run_id_q <= '0;
					idx_q    <= '0;
					vld_s1   <= 1'b0;
					state_q  <= S_RESULT;
					unique case (req_q)
						REQ_ADD: begin
							if (add_ok) begin
								done_q[cnt_q[ADDR_W-1:0]]  <= 1'b0;
								live_q[cnt_q[ADDR_W-1:0]]  <= 1'b1;
								alloc_q[cnt_q[ADDR_W-1:0]] <= 1'b0;
								cnt_q <= cnt_q + CNT_W'(1);
							end else begin
								st_q <= ST_REJECT;
							end
						end
						REQ_START: begin
							done_q  <= '0;
							live_q  <= '1;
							alloc_q <= '0;
							now_q   <= '0;
							max_q   <= '0;
						end
						REQ_RKEEP: begin
							done_q <= '0;
							live_q <= '1;
							max_q  <= now_q;
						end
						REQ_MARK: begin
							if (CMP_W'(tgt_q) >= cnt_w) begin
								st_q <= ST_REJECT;
							end else begin
								state_q <= S_MARK;
							end
						end
						REQ_EXEC: begin
							if (cnt_q == '0) begin
								st_q <= ST_NONE;
							end else begin
								state_q <= S_FIND;
							end
						end
						default: st_q <= ST_REJECT;
					endcase
				end
				S_MARK: begin
					if (alloc_q[tgt_idx]) begin
						now_q <= now_sub;
					end
					alloc_q[tgt_idx] <= 1'b0;
					live_q[tgt_idx]  <= 1'b0;
					state_q <= S_RESULT;
				end
				S_FIND: begin
					if (issue) begin
						idx_q <= idx_q + CNT_W'(1);
					end
					vld_s1 <= issue;
					e_s1   <= idx_q[ADDR_W-1:0];
					if (vld_s1 && ready_s1) begin
						run_q      <= e_s1;
						run_id_q   <= rd.id;
						run_size_q <= rd.size;
						state_q    <= S_ALLOC;
					end else if (scan_end) begin
						st_q    <= ST_NONE;
						state_q <= S_RESULT;
					end
				end
				S_ALLOC: begin
					if (!alloc_q[run_q] && run_size_q != '0) begin
						alloc_q[run_q] <= 1'b1;
						now_q <= now_add;
						if (now_add > max_q) begin
							max_q <= now_add;
						end
					end
					done_q[run_q] <= 1'b1;
					idx_q  <= '0;
					vld_s1 <= 1'b0;
					need_q <= '0;
					state_q <= rel_q ? S_NEED : S_RESULT;
				end
				S_NEED: begin
					// mark every output some unexecuted entry still reads
					if (issue) begin
						idx_q <= idx_q + CNT_W'(1);
					end
					vld_s1 <= issue;
					e_s1   <= idx_q[ADDR_W-1:0];
					if (vld_s1 && !done_q[e_s1]) begin
						if (rd.kind[1] && !rd_dep_neg && dep_in_tbl) begin
							need_q[dep_idx] <= 1'b1;
						end
						if (rd.kind == KIND_SEQ && e_s1 != '0) begin
							need_q[prev_idx] <= 1'b1;
						end
					end
					if (scan_end) begin
						idx_q   <= '0;
						state_q <= S_FREE;
					end
				end
				S_FREE: begin
					if (issue) begin
						idx_q <= idx_q + CNT_W'(1);
					end
					vld_s1 <= issue;
					e_s1   <= idx_q[ADDR_W-1:0];
					if (vld_s1 && done_q[e_s1] && live_q[e_s1] && !need_q[e_s1]) begin
						if (alloc_q[e_s1]) begin
							now_q <= now_sub;
						end
						alloc_q[e_s1] <= 1'b0;
						live_q[e_s1]  <= 1'b0;
					end
					if (scan_end) begin
						state_q <= S_RESULT;
					end
				end
				S_RESULT: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						m_tuser  <= st_q;
						m_tdata  <= {max_q, now_q, run_id_q, 8'(run_q)};
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`LDS_NEVER(a_cnt_range, cnt_q > CNT_W'(MAX_ENTRIES))
	`LDS_ASSERT(a_peak_above_now, now_q <= max_q)
	`LDS_ASSERT(a_one_in_flight, (s_tvalid && s_tready) |=> !s_tready)
endmodule
